// ===== rtl/hpa_pkg.sv =====
// Shared constants and codes for the handle pool allocator.
`timescale 1ns / 1ps

package hpa_pkg;

   localparam int POOL_SIZE = 64;
   localparam int HANDLE_W  = 6;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_TRY   = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NONE      = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;
   localparam logic [1:0] ST_EXHAUSTED = 2'd3;

endpackage

// ===== rtl/hpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/handle_pool_allocator.sv =====
// Top level of the handle pool allocator: command sequencer, in-use bitmap and free FIFO.
`timescale 1ns / 1ps
// A result is registered in S_EXEC after the accept step; an earlier result still
// held by rsp_stall delays it. A new command is taken only in S_IDLE, so commands
// never overlap: the accept step reads the bitmap and free-list memories, and S_EXEC
// modifies and writes them back. Reset: synchronous; counters, FIFO pointers and the
// per-entry bitmap valid bits clear at once, so commands are accepted right after reset.

module handle_pool_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_command,
   input  logic [hpa_pkg::HANDLE_W-1:0] req_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hpa_pkg::HANDLE_W-1:0] rsp_handle_res,
   output logic [1:0]                   rsp_status
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type                        state_ff, state_in;
   logic [1:0]                       cmd_ff;
   logic [hpa_pkg::HANDLE_W-1:0]     hdl_ff;
   logic [hpa_pkg::IDX_W-1:0]        head_ff, head_in;
   logic [hpa_pkg::IDX_W-1:0]        tail_ff, tail_in;
   logic [hpa_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [hpa_pkg::CNT_W-1:0]        issued_ff, issued_in;
   logic [hpa_pkg::POOL_SIZE-1:0]    vld_ff;
   logic                             rsp_valid_ff;
   logic [hpa_pkg::HANDLE_W-1:0]     rsp_handle_res_ff, rsp_handle_res_in;
   logic [1:0]                       rsp_status_ff, rsp_status_in;

   logic                             accept;
   logic                             exec_go;
   logic                             use_we;
   logic [hpa_pkg::IDX_W-1:0]        use_wa;
   logic                             use_wd;
   logic [0:0]                       use_rd;
   logic                             q_we;
   logic [hpa_pkg::IDX_W-1:0]        q_rd;
   logic [hpa_pkg::IDX_W-1:0]        hdl_idx;
   logic                             hdl_in_range;
   logic                             hdl_in_use;
   logic                             have_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign exec_go   = (state_ff == S_EXEC) && !(rsp_valid_ff && rsp_stall);

   assign hdl_idx      = hdl_ff[hpa_pkg::IDX_W-1:0];
   assign hdl_in_range = ({1'b0, hdl_ff} < (hpa_pkg::HANDLE_W+1)'(hpa_pkg::POOL_SIZE));
   assign hdl_in_use   = hdl_in_range && vld_ff[hdl_idx] && use_rd[0];
   assign have_free    = (count_ff != '0);

   hpa_ram #(.WIDTH(1), .DEPTH(hpa_pkg::POOL_SIZE)) u_in_use (
      .clock   (clock),
      .wr_en   (use_we),
      .wr_addr (use_wa),
      .wr_data (use_wd),
      .rd_en   (accept),
      .rd_addr (req_handle[hpa_pkg::IDX_W-1:0]),
      .rd_data (use_rd)
   );

   hpa_ram #(.WIDTH(hpa_pkg::IDX_W), .DEPTH(hpa_pkg::POOL_SIZE)) u_free_q (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (hdl_idx),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (q_rd)
   );

   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      issued_in         = issued_ff;
      use_we            = 1'b0;
      use_wa            = hdl_idx;
      use_wd            = 1'b0;
      q_we              = 1'b0;
      rsp_handle_res_in = '0;
      rsp_status_in     = hpa_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
               case (cmd_ff)
                  hpa_pkg::CMD_ALLOC, hpa_pkg::CMD_TRY: begin
                     if (have_free) begin
                        // pop oldest freed handle and mark it held
                        rsp_handle_res_in = hpa_pkg::HANDLE_W'(q_rd);
                        use_we   = 1'b1;
                        use_wa   = q_rd;
                        use_wd   = 1'b1;
                        head_in  = (head_ff == hpa_pkg::IDX_W'(hpa_pkg::POOL_SIZE - 1)) ?
                                   '0 : head_ff + 1'b1;
                        count_in = count_ff - 1'b1;
                     end else if (cmd_ff == hpa_pkg::CMD_TRY) begin
                        rsp_status_in = hpa_pkg::ST_NONE;
                     end else if (issued_ff < hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE)) begin
                        rsp_handle_res_in = hpa_pkg::HANDLE_W'(issued_ff);
                        use_we    = 1'b1;
                        use_wa    = issued_ff[hpa_pkg::IDX_W-1:0];
                        use_wd    = 1'b1;
                        issued_in = issued_ff + 1'b1;
                     end else begin
                        rsp_status_in = hpa_pkg::ST_EXHAUSTED;
                     end
                  end
                  hpa_pkg::CMD_FREE: begin
                     if (hdl_in_use) begin
                        // clear the mark and queue the handle at the tail
                        use_we   = 1'b1;
                        use_wd   = 1'b0;
                        q_we     = 1'b1;
                        tail_in  = (tail_ff == hpa_pkg::IDX_W'(hpa_pkg::POOL_SIZE - 1)) ?
                                   '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = hpa_pkg::ST_INVALID;
                     end
                  end
                  default: begin
                     rsp_status_in = hpa_pkg::ST_OK;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         issued_ff    <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         issued_ff <= issued_in;
         if (use_we) begin
            vld_ff[use_wa] <= 1'b1;
         end
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         cmd_ff <= req_command;
         hdl_ff <= req_handle;
      end
      if (exec_go) begin
         rsp_handle_res_ff <= rsp_handle_res_in;
         rsp_status_ff     <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_res = rsp_handle_res_ff;
   assign rsp_status     = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= issued_ff)
      else $error("free count exceeds issued handles");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issued_ff <= hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE))
      else $error("issued count beyond pool size");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("completed command produced no result");

   a_error_zero_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != hpa_pkg::ST_OK) |-> rsp_handle_res_ff == '0)
      else $error("failed command returned a nonzero handle");

endmodule
